[rtl/core/pwle_pkg.sv]
// Package for the pulse-width line encoder core.
// Holds configuration constants, register indexes and shared types.
// Depends on nothing.
package pwle_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int SEG_PER_BYTE  = 2 * BITS_PER_BYTE + 2;
	localparam int SEG_W         = $clog2(SEG_PER_BYTE);
	localparam int SHIFT_W       = (BITS_PER_BYTE > 8) ? BITS_PER_BYTE : 8;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = $clog2(QDEPTH);
	localparam int QCNT_W        = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_HIGH = 2'd3;

	localparam logic [9:0] START_LOW_RESET = 10'd100;
	localparam logic [7:0] LONG_RESET      = 8'd4;
	localparam logic [7:0] SHORT_RESET     = 8'd2;
	localparam logic [7:0] STOP_HIGH_RESET = 8'd6;

	typedef struct packed {
		logic [9:0] start_low_ticks;
		logic [7:0] long_ticks;
		logic [7:0] short_ticks;
		logic [7:0] stop_high_ticks;
	} pwle_cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} pwle_item_t;

endpackage

[rtl/core/pwle_front.sv]
// Front end of the pulse-width line encoder: input handshake and item queue.
// Accepted bytes wait here until the segment sequencer takes them.
// Depends on pwle_pkg.
module pwle_front
	import pwle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       q_valid,
	output pwle_item_t q_item,
	input  logic       q_pop
);

	pwle_item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;
	logic                    push;
	logic                    pop;

	assign in_stall = (count_q == QCNT_W'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data_byte: data_byte, last_byte: last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/pwle_back.sv]
// Back end of the pulse-width line encoder: segment sequencer and output register.
// Turns one queued byte into its start, bit and stop segments, one per cycle while out_stall is low.
// Depends on pwle_pkg.
module pwle_back
	import pwle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pwle_cfg_t  cfg,
	input  logic       q_valid,
	input  pwle_item_t q_item,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       line_level,
	output logic [9:0] duration_ticks,
	output logic       end_of_byte,
	output logic       release_line
);

	localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SEG_PER_BYTE - 1);

	logic               busy_q;
	logic [SEG_W-1:0]   seg_q;
	logic               half_q;
	logic [SHIFT_W-1:0] bits_q;
	logic               last_q;
	logic               out_valid_q;
	logic               level_q;
	logic [9:0]         dur_q;
	logic               eob_q;
	logic               rel_q;
	logic               adv;
	logic               is_stop;
	logic [9:0]         start_dur;
	logic [7:0]         long_dur;
	logic [7:0]         short_dur;
	logic [7:0]         stop_dur;
	logic [7:0]         bit_dur;

	assign adv     = !out_valid_q || !out_stall;
	assign q_pop   = adv && !busy_q && q_valid;
	assign is_stop = (seg_q == LAST_SEG);

	assign start_dur = (cfg.start_low_ticks == '0) ? 10'd1 : cfg.start_low_ticks;
	assign long_dur  = (cfg.long_ticks == '0) ? 8'd1 : cfg.long_ticks;
	assign short_dur = (cfg.short_ticks == '0) ? 8'd1 : cfg.short_ticks;
	assign stop_dur  = (cfg.stop_high_ticks == '0) ? 8'd1 : cfg.stop_high_ticks;
	assign bit_dur   = (bits_q[0] ^ half_q) ? long_dur : short_dur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			seg_q       <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (is_stop) begin
					busy_q <= 1'b0;
					seg_q  <= '0;
				end else begin
					seg_q  <= seg_q + 1'b1;
					half_q <= !half_q;
				end
			end else if (q_valid) begin
				out_valid_q <= 1'b1;
				busy_q      <= 1'b1;
				seg_q       <= SEG_W'(1);
				half_q      <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				if (is_stop) begin
					level_q <= 1'b1;
					dur_q   <= {2'b00, stop_dur};
					eob_q   <= 1'b1;
					rel_q   <= last_q;
				end else begin
					level_q <= !half_q;
					dur_q   <= {2'b00, bit_dur};
					eob_q   <= 1'b0;
					rel_q   <= 1'b0;
					if (half_q) begin
						bits_q <= bits_q >> 1;
					end
				end
			end else if (q_valid) begin
				level_q <= 1'b0;
				dur_q   <= start_dur;
				eob_q   <= 1'b0;
				rel_q   <= 1'b0;
				bits_q  <= SHIFT_W'(q_item.data_byte);
				last_q  <= q_item.last_byte;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign line_level     = level_q;
	assign duration_ticks = dur_q;
	assign end_of_byte    = eob_q;
	assign release_line   = rel_q;

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (seg_q != '0) && (seg_q <= LAST_SEG))
		else $error("segment counter out of range while busy");

	a_stop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && adv && is_stop |=> !busy_q && out_valid_q && eob_q)
		else $error("stop segment did not close the run");

	a_release_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rel_q |-> eob_q && level_q)
		else $error("line release outside a stop segment");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> busy_q && (seg_q == SEG_W'(1)) && !eob_q)
		else $error("new byte did not start with its start pulse");

endmodule

[rtl/core/pulse_width_line_encoder_core.sv]
// Top level of the pulse-width line encoder: configuration registers,
// input queue and segment sequencer. Depends on pwle_pkg, pwle_front, pwle_back.
//
// Each accepted byte becomes 2*BITS_PER_BYTE+2 segments (18 for eight bits):
// a low start pulse, two segments per bit least significant first, and a high
// stop segment that carries end_of_byte and, for a last byte, release_line.
// Segments leave the sequencer one per cycle while out_stall is low, and bytes
// follow each other with no gap; a two-entry queue in front lets new bytes be
// accepted while the current one is still being sent.
// A duration register holding zero gives one-tick segments.
module pulse_width_line_encoder_core
	import pwle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  line_level,
	output logic [9:0]            duration_ticks,
	output logic                  end_of_byte,
	output logic                  release_line
);

	pwle_cfg_t  cfg_q;
	logic       q_valid;
	pwle_item_t q_item;
	logic       q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks <= START_LOW_RESET;
			cfg_q.long_ticks      <= LONG_RESET;
			cfg_q.short_ticks     <= SHORT_RESET;
			cfg_q.stop_high_ticks <= STOP_HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_LOW: cfg_q.start_low_ticks <= cfg_wdata;
				CFG_LONG:      cfg_q.long_ticks      <= cfg_wdata[7:0];
				CFG_SHORT:     cfg_q.short_ticks     <= cfg_wdata[7:0];
				CFG_STOP_HIGH: cfg_q.stop_high_ticks <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	pwle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	pwle_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_level     (line_level),
		.duration_ticks (duration_ticks),
		.end_of_byte    (end_of_byte),
		.release_line   (release_line)
	);

endmodule

[dv/pwle_segment_checker.sv]
// Segment checker for the pulse-width line encoder core: watches the configuration,
// byte and segment channels, predicts each byte's segment run and compares it.
// Depends on pwle_pkg for register indexes, reset values and the timing struct.
module pwle_segment_checker
	import pwle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  line_level,
	input  logic [9:0]            duration_ticks,
	input  logic                  end_of_byte,
	input  logic                  release_line,
	output int unsigned           n_fail,
	output int unsigned           n_pending,
	output int unsigned           n_bytes,
	output int unsigned           n_segments
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PRINT_CAP = 40;

	typedef struct packed {
		logic       level;
		logic [9:0] ticks;
		logic       eob;
		logic       rel;
	} segment_t;

	segment_t    expected_segments[$];
	pwle_cfg_t   timing;
	int unsigned fail_count = 0;
	int unsigned byte_count = 0;
	int unsigned seg_count  = 0;

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		fail_count++;
	endtask

	function automatic logic [9:0] hold_ticks(input logic [9:0] t);
		return (t == 10'd0) ? 10'd1 : t;
	endfunction

	task automatic encode_byte(input logic [7:0] d, input logic l);
		logic [9:0] long_t;
		logic [9:0] short_t;
		logic       bit_val;
		long_t  = hold_ticks({2'b00, timing.long_ticks});
		short_t = hold_ticks({2'b00, timing.short_ticks});
		expected_segments.push_back('{1'b0, hold_ticks(timing.start_low_ticks), 1'b0, 1'b0});
		for (int i = 0; i < BITS_PER_BYTE; i++) begin
			bit_val = (i < 8) ? d[i[2:0]] : 1'b0;
			if (bit_val) begin
				expected_segments.push_back('{1'b1, long_t, 1'b0, 1'b0});
				expected_segments.push_back('{1'b0, short_t, 1'b0, 1'b0});
			end else begin
				expected_segments.push_back('{1'b1, short_t, 1'b0, 1'b0});
				expected_segments.push_back('{1'b0, long_t, 1'b0, 1'b0});
			end
		end
		expected_segments.push_back('{1'b1, hold_ticks({2'b00, timing.stop_high_ticks}),
			1'b1, l});
	endtask

	always @(posedge clk or negedge arst_n) begin
		segment_t got;
		segment_t want;
		if (!arst_n) begin
			timing = '{START_LOW_RESET, LONG_RESET, SHORT_RESET, STOP_HIGH_RESET};
			expected_segments.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_LOW: timing.start_low_ticks = cfg_wdata[9:0];
					CFG_LONG:      timing.long_ticks      = cfg_wdata[7:0];
					CFG_SHORT:     timing.short_ticks     = cfg_wdata[7:0];
					CFG_STOP_HIGH: timing.stop_high_ticks = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				encode_byte(data_byte, last_byte);
				byte_count++;
			end
			if (out_valid && !out_stall) begin
				got = '{line_level, duration_ticks, end_of_byte, release_line};
				seg_count++;
				if (expected_segments.size() == 0) begin
					report_mismatch($sformatf(
						"unexpected segment level=%b ticks=%0d eob=%b rel=%b",
						got.level, got.ticks, got.eob, got.rel));
				end else begin
					want = expected_segments.pop_front();
					if (got.level !== want.level)
						report_mismatch($sformatf("segment %0d line_level %b, expected %b",
							seg_count, got.level, want.level));
					if (got.ticks !== want.ticks)
						report_mismatch($sformatf("segment %0d duration_ticks %0d, expected %0d",
							seg_count, got.ticks, want.ticks));
					if (got.eob !== want.eob)
						report_mismatch($sformatf("segment %0d end_of_byte %b, expected %b",
							seg_count, got.eob, want.eob));
					if (got.rel !== want.rel)
						report_mismatch($sformatf("segment %0d release_line %b, expected %b",
							seg_count, got.rel, want.rel));
				end
			end
		end
		n_fail     <= fail_count;
		n_pending  <= expected_segments.size();
		n_bytes    <= byte_count;
		n_segments <= seg_count;
	end

endmodule

[dv/pulse_width_line_encoder_core_tb.sv]
// Top of the pulse-width line encoder core testbench: clock, reset, byte stimulus,
// receiver stalls, timing register phases, watchdog and verdict.
// Depends on pwle_pkg, pulse_width_line_encoder_core and pwle_segment_checker.
module pulse_width_line_encoder_core_tb
	import pwle_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned RANDOM_PHASES  = 5;
	localparam int unsigned PHASE_BYTES    = 60;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index      = CFG_START_LOW;
	logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte      = 8'h00;
	logic                  last_byte      = 1'b0;
	logic                  out_valid;
	logic                  out_stall      = 1'b0;
	logic                  line_level;
	logic [9:0]            duration_ticks;
	logic                  end_of_byte;
	logic                  release_line;

	int unsigned n_fail;
	int unsigned n_pending;
	int unsigned n_bytes;
	int unsigned n_segments;
	int unsigned n_settings  = 1;
	int unsigned idle_cycles = 0;

	int unsigned stall_mode      = 0;
	int unsigned stall_mode_left = 0;
	int unsigned stall_hold      = 0;
	int unsigned stall_tick      = 0;

	pulse_width_line_encoder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_level     (line_level),
		.duration_ticks (duration_ticks),
		.end_of_byte    (end_of_byte),
		.release_line   (release_line)
	);

	pwle_segment_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.line_level     (line_level),
		.duration_ticks (duration_ticks),
		.end_of_byte    (end_of_byte),
		.release_line   (release_line),
		.n_fail         (n_fail),
		.n_pending      (n_pending),
		.n_bytes        (n_bytes),
		.n_segments     (n_segments)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The receiver switches between free running, random stalls, long stall
	// stretches and a fixed periodic stall.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_mode_left == 0) begin
			stall_mode      <= $urandom_range(0, 3);
			stall_mode_left <= $urandom_range(50, 300);
		end else begin
			stall_mode_left <= stall_mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: begin
				if (stall_hold != 0) begin
					stall_hold <= stall_hold - 1;
				end else begin
					out_stall  <= ~out_stall;
					stall_hold <= $urandom_range(0, 20);
				end
			end
			default: out_stall <= (stall_tick % 3 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a beat.", idle_cycles);
				$display("pulse_width_line_encoder_core test failed");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] d, input logic l);
		in_valid  <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_all_segments(input int unsigned settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_timing(input logic [9:0] start_t, input logic [9:0] long_t,
		input logic [9:0] short_t, input logic [9:0] stop_t);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_LOW;
		cfg_wdata <= start_t;
		@(posedge clk);
		cfg_index <= CFG_LONG;
		cfg_wdata <= long_t;
		@(posedge clk);
		cfg_index <= CFG_SHORT;
		cfg_wdata <= short_t;
		@(posedge clk);
		cfg_index <= CFG_STOP_HIGH;
		cfg_wdata <= stop_t;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		repeat (2) @(posedge clk);
	endtask

	// Mostly whole messages with the last flag on their final byte, some
	// noise on the flag, sent in bursts with random gaps.
	task automatic send_random_bytes(input int unsigned count);
		int unsigned msg_left;
		int unsigned burst_left;
		logic [7:0]  d;
		logic        l;
		msg_left   = 0;
		burst_left = $urandom_range(1, 12);
		for (int unsigned k = 0; k < count; k++) begin
			if (msg_left == 0) msg_left = $urandom_range(1, 6);
			l = (msg_left == 1);
			if ($urandom_range(0, 9) == 0) l = 1'($urandom_range(0, 1));
			msg_left--;
			case ($urandom_range(0, 9))
				0:       d = 8'h00;
				1:       d = 8'hFF;
				default: d = 8'($urandom_range(0, 255));
			endcase
			push_byte(d, l);
			if ($urandom_range(0, 59) == 0) begin
				wait_all_segments(0);
			end else if (burst_left <= 1) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	initial begin
		logic [8:0] dflt_bytes[10];
		logic [8:0] full_bytes[3];
		logic [8:0] zero_bytes[3];
		logic [8:0] mask_bytes[2];
		dflt_bytes = '{{8'h00, 1'b0}, {8'hFF, 1'b0}, {8'h01, 1'b0}, {8'h80, 1'b1},
			{8'h55, 1'b0}, {8'hAA, 1'b1}, {8'hFF, 1'b1}, {8'h00, 1'b1},
			{8'h0F, 1'b0}, {8'hF0, 1'b1}};
		full_bytes = '{{8'hA5, 1'b0}, {8'h5A, 1'b1}, {8'hFF, 1'b1}};
		zero_bytes = '{{8'h00, 1'b0}, {8'hFF, 1'b1}, {8'hC3, 1'b0}};
		mask_bytes = '{{8'h96, 1'b0}, {8'h69, 1'b1}};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dflt_bytes[i]) push_byte(dflt_bytes[i][8:1], dflt_bytes[i][0]);
		wait_all_segments(SETTLE_CYCLES);

		set_timing(10'd1023, 10'd255, 10'd255, 10'd255);
		foreach (full_bytes[i]) push_byte(full_bytes[i][8:1], full_bytes[i][0]);
		wait_all_segments(SETTLE_CYCLES);

		// Zero in every register must still give one-tick segments.
		set_timing(10'd0, 10'd0, 10'd0, 10'd0);
		foreach (zero_bytes[i]) push_byte(zero_bytes[i][8:1], zero_bytes[i][0]);
		wait_all_segments(SETTLE_CYCLES);

		// Upper write bits on the 8-bit registers have to be dropped.
		set_timing(10'd1, 10'h305, 10'h203, 10'h1FF);
		foreach (mask_bytes[i]) push_byte(mask_bytes[i][8:1], mask_bytes[i][0]);
		wait_all_segments(SETTLE_CYCLES);

		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			set_timing(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
				10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
			send_random_bytes(PHASE_BYTES);
			wait_all_segments(SETTLE_CYCLES);
		end

		$display("Sent %0d bytes as %0d segments under %0d timing settings.",
			n_bytes, n_segments, n_settings);
		$display("Settings spanned reset values, full scale, all zero and masked writes.");
		if (n_fail == 0) begin
			$display("pulse_width_line_encoder_core test passed");
		end else begin
			$display("%0d mismatches found.", n_fail);
			$display("pulse_width_line_encoder_core test failed");
		end
		$finish;
	end

endmodule
